FILE: design/lwfr_pkg.sv
// ----------------------------------------------------------------------------
// lwfr_pkg
// Shared types and codes for the loss window FEC ratio tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lwfr_pkg;

	localparam int PN_W  = 62;
	localparam int OP_W  = 2;
	localparam int OUT_W = 7;

	// event kinds
	localparam logic [OP_W-1:0] OP_ACK    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOST   = 2'd1;
	localparam logic [OP_W-1:0] OP_REPAIR = 2'd2;
	localparam logic [OP_W-1:0] OP_BAD    = 2'd3;

	// ring entry status
	localparam logic [1:0] RS_UNACKED = 2'd0;
	localparam logic [1:0] RS_ACKED   = 2'd1;
	localparam logic [1:0] RS_LOST    = 2'd2;
	localparam logic [1:0] RS_REPAIR  = 2'd3;

	localparam logic [OUT_W-1:0] SAT_MAX = 7'd127;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [PN_W-1:0] packet_number;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] fec_period;
		logic [OUT_W-1:0] lost_count;
		logic [OUT_W-1:0] repair_count;
		logic             ignored;
	} rsp_t;

endpackage

`default_nettype wire

FILE: design/loss_window_fec_ratio.sv
// ----------------------------------------------------------------------------
// loss_window_fec_ratio
// Per-path ring of packet status with lost/repaired counts and FEC period.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_ready is low while it is processed.
// Ring slots are kept relative to the highest number seen: that number sits at
// hslot and a number n below it sits n slots back, so a packet number is never
// reduced modulo the window. An undefined kind or a number that is too old is
// answered as ignored, and an old or repeated number is written in place. A
// newer number within a window is reached by a gap fill that writes one ring
// slot per cycle, and a jump of more than a full window clears the ring. The
// count scan reads one slot per cycle through the single ring read port and the
// divider makes one quotient bit per cycle; when nothing is lost or repaired
// the divider is skipped. req_ready rises together with rsp_valid, and a
// finished request waits while the previous response is still held. After
// reset the ring is cleared before the first request is taken.
`default_nettype none

module loss_window_fec_ratio #(
	parameter int WINDOW_SIZE = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire lwfr_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output lwfr_pkg::rsp_t     rsp
);

	import lwfr_pkg::*;

	localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CW = $clog2(WINDOW_SIZE + 1);
	localparam int XW = (CW > OUT_W) ? CW : OUT_W;
	localparam int DW = PN_W + 1;

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_EVAL     = 4'd2;
	localparam logic [3:0] S_CLASS    = 4'd3;
	localparam logic [3:0] S_GAP      = 4'd4;
	localparam logic [3:0] S_CLEAR    = 4'd6;
	localparam logic [3:0] S_PUT      = 4'd7;
	localparam logic [3:0] S_SCAN     = 4'd8;
	localparam logic [3:0] S_SCAN_END = 4'd9;
	localparam logic [3:0] S_DIV      = 4'd10;
	localparam logic [3:0] S_DWAIT    = 4'd11;
	localparam logic [3:0] S_FINISH   = 4'd12;

	logic [3:0]      state_q;
	logic [OP_W-1:0] op_q;
	logic [PN_W-1:0] pn_q;
	logic [PN_W-1:0] hs_q;
	logic [AW-1:0]   hslot_q;
	logic [DW-1:0]   d_q;
	logic [CW-1:0]   rem_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   slot_q;
	logic [CW-1:0]   lcnt_q;
	logic [CW-1:0]   rcnt_q;
	logic [OUT_W-1:0] ratio_q;
	logic            ign_q;
	logic            rvalid_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [1:0] ring_mem [WINDOW_SIZE];
	logic [1:0] rdata_q;

	logic          ring_we;
	logic [AW-1:0] ring_waddr;
	logic [1:0]    ring_wdata;
	logic [AW-1:0] ptr_next;
	logic [1:0]    status;
	logic          newer;
	logic          far;
	logic [DW-1:0] nd;
	logic          too_old;
	logic [AW:0]   back_slot;
	logic [CW-1:0] loss_sum;
	logic          div_start;
	logic          div_done;
	logic [CW-1:0] div_quo;
	logic [XW-1:0] quo_x;
	logic [XW-1:0] lcnt_x;
	logic [XW-1:0] rcnt_x;
	logic [OUT_W-1:0] quo_sat;
	logic          last_slot;

	always_comb begin
		case (op_q)
			OP_ACK:    status = RS_ACKED;
			OP_LOST:   status = RS_LOST;
			OP_REPAIR: status = RS_REPAIR;
			default:   status = RS_UNACKED;
		endcase
	end

	assign last_slot = (ptr_q == AW'(WINDOW_SIZE - 1));
	assign ptr_next  = last_slot ? '0 : ptr_q + 1'b1;

	// d_q = pn - highest, as a 63-bit two's complement difference
	assign newer   = !d_q[DW-1] && (d_q != '0);
	assign far     = d_q > DW'(WINDOW_SIZE);
	assign nd      = '0 - d_q;
	assign too_old = nd >= DW'(WINDOW_SIZE);
	assign back_slot = ({1'b0, hslot_q} >= {1'b0, nd[AW-1:0]})
		? {1'b0, hslot_q} - {1'b0, nd[AW-1:0]}
		: {1'b0, hslot_q} + (AW+1)'(WINDOW_SIZE) - {1'b0, nd[AW-1:0]};

	assign loss_sum  = CW'(lcnt_q + rcnt_q);
	assign div_start = (state_q == S_DIV) && (loss_sum != '0);

	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = ptr_q;
		ring_wdata = RS_UNACKED;
		case (state_q)
			S_INIT, S_CLEAR: begin
				ring_we = 1'b1;
			end
			S_GAP: begin
				ring_we    = 1'b1;
				ring_waddr = ptr_next;
				ring_wdata = (rem_q == CW'(1)) ? status : RS_UNACKED;
			end
			S_PUT: begin
				ring_we    = 1'b1;
				ring_waddr = slot_q;
				ring_wdata = status;
			end
			default: begin
				ring_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_waddr] <= ring_wdata;
		rdata_q <= ring_mem[ptr_q];
	end

	lwfr_div #(
		.WIDTH    (CW),
		.DIVIDEND (WINDOW_SIZE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (loss_sum),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo_x   = XW'(div_quo);
	assign lcnt_x  = XW'(lcnt_q);
	assign rcnt_x  = XW'(rcnt_q);
	assign quo_sat = (quo_x > XW'(SAT_MAX)) ? SAT_MAX : quo_x[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			op_q        <= OP_ACK;
			pn_q        <= '0;
			hs_q        <= '0;
			hslot_q     <= '0;
			d_q         <= '0;
			rem_q       <= '0;
			ptr_q       <= '0;
			slot_q      <= '0;
			lcnt_q      <= '0;
			rcnt_q      <= '0;
			ratio_q     <= '0;
			ign_q       <= 1'b0;
			rvalid_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rvalid_q <= (state_q == S_SCAN);
			if (rvalid_q) begin
				if (rdata_q == RS_LOST)
					lcnt_q <= lcnt_q + 1'b1;
				else if (rdata_q == RS_REPAIR)
					rcnt_q <= rcnt_q + 1'b1;
			end
			if (rsp_valid_q && rsp_ready && (state_q != S_FINISH))
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_INIT: begin
					ptr_q <= ptr_next;
					if (last_slot)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.operation;
						pn_q    <= req.packet_number;
						ign_q   <= 1'b0;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					d_q <= {1'b0, pn_q} - {1'b0, hs_q};
					if (op_q == OP_BAD) begin
						ign_q   <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					if (newer && far) begin
						ptr_q   <= '0;
						state_q <= S_CLEAR;
					end else if (newer) begin
						rem_q   <= d_q[CW-1:0];
						ptr_q   <= hslot_q;
						state_q <= S_GAP;
					end else if (too_old) begin
						ign_q   <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						slot_q  <= back_slot[AW-1:0];
						state_q <= S_PUT;
					end
				end
				S_GAP: begin
					// skipped slots go unacked, the last step lands on the new number
					rem_q <= rem_q - 1'b1;
					if (rem_q == CW'(1)) begin
						hslot_q <= ptr_next;
						hs_q    <= pn_q;
						lcnt_q  <= '0;
						rcnt_q  <= '0;
						ptr_q   <= '0;
						state_q <= S_SCAN;
					end else begin
						ptr_q <= ptr_next;
					end
				end
				S_CLEAR: begin
					ptr_q <= ptr_next;
					if (last_slot) begin
						// ring is empty, so the new number keeps the current slot
						slot_q  <= hslot_q;
						hs_q    <= pn_q;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					lcnt_q  <= '0;
					rcnt_q  <= '0;
					ptr_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					ptr_q <= ptr_next;
					if (last_slot)
						state_q <= S_SCAN_END;
				end
				S_SCAN_END: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= (loss_sum != '0) ? S_DWAIT : S_FINISH;
				end
				S_DWAIT: begin
					if (div_done) begin
						ratio_q <= quo_sat;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.fec_period   <= ratio_q;
						rsp_q.lost_count   <= (lcnt_x > XW'(SAT_MAX)) ? SAT_MAX
							: lcnt_x[OUT_W-1:0];
						rsp_q.repair_count <= (rcnt_x > XW'(SAT_MAX)) ? SAT_MAX
							: rcnt_x[OUT_W-1:0];
						rsp_q.ignored      <= ign_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a request is never followed by another in the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while busy");

	// counted entries cannot exceed the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, lcnt_q} + {1'b0, rcnt_q}) <= (CW+1)'(WINDOW_SIZE))
		else $error("lost plus repaired exceeds window");

	// highest slot index stays inside the ring
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, hslot_q} < (AW+1)'(WINDOW_SIZE))
		else $error("highest slot out of range");

	// divider result only arrives while waiting for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DWAIT))
		else $error("divider done outside wait");

endmodule

`default_nettype wire

FILE: design/lwfr_div.sv
// ----------------------------------------------------------------------------
// lwfr_div
// Restoring divider, one quotient bit per cycle, constant dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module lwfr_div #(
	parameter int WIDTH    = 7,
	parameter int DIVIDEND = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic      [WIDTH-1:0] quotient
);

	localparam int NW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvd_q;
	logic [NW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   trial;
	logic             ge;

	assign trial = {rem_q, dvd_q[WIDTH-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvd_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= '0;
				dvd_q  <= WIDTH'(DIVIDEND);
				cnt_q  <= NW'(WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? WIDTH'(trial - {1'b0, divisor}) : trial[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], ge};
				dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: bench/lwfr_ratio_checker.sv
// ----------------------------------------------------------------------------
// lwfr_ratio_checker
// Watches both channels of the loss window tracker, predicts each report from
// its own copy of the status ring and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lwfr_ratio_checker #(
	parameter int WINDOW = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_ready,
	input  wire lwfr_pkg::req_t req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_ready,
	input  wire lwfr_pkg::rsp_t rsp,
	output int                  fails,
	output int                  pending
);

	import lwfr_pkg::*;

	logic [1:0]       slot_state [WINDOW];
	logic [63:0]      top_pn;
	logic [OUT_W-1:0] period_now;
	rsp_t             ratio_reports [$];
	int               miss_count;

	function automatic logic [OUT_W-1:0] clip7(input int v);
		return (v > int'(SAT_MAX)) ? SAT_MAX : OUT_W'(v);
	endfunction

	// Applies one event to the ring and returns the report it causes.
	function automatic rsp_t apply_event(input req_t ev);
		logic [63:0] pn;
		logic [63:0] gap;
		logic [63:0] k;
		logic        drop;
		int          i;
		int          n_lost;
		int          n_rep;
		rsp_t        res;
		pn = {2'b00, ev.packet_number};
		drop = 1'b0;
		n_lost = 0;
		n_rep = 0;
		if (ev.operation == OP_BAD) begin
			drop = 1'b1;
		end else if (pn > top_pn) begin
			gap = pn - top_pn - 64'd1;
			if (gap >= 64'(WINDOW)) begin
				for (i = 0; i < WINDOW; i++)
					slot_state[i] = RS_UNACKED;
			end else begin
				for (k = 0; k < gap; k++)
					slot_state[int'((top_pn + 64'd1 + k) % 64'(WINDOW))] = RS_UNACKED;
			end
			top_pn = pn;
		end else if (top_pn - pn >= 64'(WINDOW)) begin
			drop = 1'b1;
		end

		if (!drop) begin
			case (ev.operation)
				OP_ACK:  slot_state[int'(pn % 64'(WINDOW))] = RS_ACKED;
				OP_LOST: slot_state[int'(pn % 64'(WINDOW))] = RS_LOST;
				default: slot_state[int'(pn % 64'(WINDOW))] = RS_REPAIR;
			endcase
		end

		for (i = 0; i < WINDOW; i++) begin
			if (slot_state[i] == RS_LOST)
				n_lost++;
			else if (slot_state[i] == RS_REPAIR)
				n_rep++;
		end

		// period holds its last value while nothing is lost or repaired
		if (!drop && n_lost + n_rep != 0)
			period_now = clip7(WINDOW / (n_lost + n_rep));

		res.fec_period   = period_now;
		res.lost_count   = clip7(n_lost);
		res.repair_count = clip7(n_rep);
		res.ignored      = drop;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < WINDOW; i++)
				slot_state[i] = RS_UNACKED;
			top_pn = '0;
			period_now = '0;
			ratio_reports.delete();
			miss_count = 0;
		end else begin
			// a report always belongs to an earlier request, so pop first
			if (rsp_valid && rsp_ready) begin
				if (ratio_reports.size() == 0) begin
					miss_count++;
					if (miss_count <= 10)
						$display("unexpected report: period %0d lost %0d repair %0d ignored %0d",
							rsp.fec_period, rsp.lost_count, rsp.repair_count, rsp.ignored);
				end else begin
					want = ratio_reports.pop_front();
					if (rsp.fec_period !== want.fec_period ||
						rsp.lost_count !== want.lost_count ||
						rsp.repair_count !== want.repair_count ||
						rsp.ignored !== want.ignored) begin
						miss_count++;
						if (miss_count <= 10)
							$display({"report mismatch: period exp %0d got %0d, lost exp %0d got %0d,",
								" repair exp %0d got %0d, ignored exp %0d got %0d"},
								want.fec_period, rsp.fec_period, want.lost_count, rsp.lost_count,
								want.repair_count, rsp.repair_count, want.ignored, rsp.ignored);
					end
				end
			end
			if (req_valid && req_ready)
				ratio_reports.push_back(apply_event(req));
		end
		fails <= miss_count;
		pending <= ratio_reports.size();
	end

endmodule

`default_nettype wire

FILE: bench/loss_window_fec_ratio_tb.sv
// ----------------------------------------------------------------------------
// loss_window_fec_ratio_tb
// Drives acked, lost and repaired events into the tracker: a directed opening
// over window edges, gap fills, old and undefined events, then random traffic
// around the highest packet number with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module loss_window_fec_ratio_tb;

	import lwfr_pkg::*;

	localparam int          WINDOW   = 64;
	localparam int          N_RANDOM = 1530;
	localparam int unsigned HOLD_AT  = 300;
	localparam int unsigned HOLD_LEN = 3000;
	localparam int          DRAIN    = 400;
	localparam int unsigned LIMIT    = 6000000;
	localparam logic [63:0] PN_MAX   = (64'd1 << PN_W) - 64'd1;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	int          fails;
	int          pending;
	int unsigned cycle_count = 0;

	// stimulus shaping only: highest number among accepted events of a defined kind
	logic [63:0] front;
	int unsigned loss_pct;
	bit          calm;

	loss_window_fec_ratio #(.WINDOW_SIZE(WINDOW)) dut (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp
	);

	lwfr_ratio_checker #(.WINDOW(WINDOW)) ratio_check (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.fails, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("loss_window_fec_ratio regression: fail");
			$finish;
		end
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 90)
			return $urandom_range(0, 4);
		if (r < 97)
			return $urandom_range(5, 40);
		return $urandom_range(60, 400);
	endfunction

	function automatic logic [63:0] rand_pn();
		return {$urandom, $urandom} & PN_MAX;
	endfunction

	function automatic logic [63:0] step_back(input logic [63:0] d);
		return (front >= d) ? front - d : front + 64'd1;
	endfunction

	function automatic logic [OP_W-1:0] event_op();
		if ($urandom_range(0, 99) < loss_pct)
			return $urandom_range(0, 1) ? OP_LOST : OP_REPAIR;
		return OP_ACK;
	endfunction

	task automatic offer(input logic [OP_W-1:0] op, input logic [63:0] pn);
		req_t        item;
		int unsigned gap;
		item.operation = op;
		item.packet_number = pn[PN_W-1:0];
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (op != OP_BAD && pn > front)
			front = pn;
		gap = calm ? 0 : idle_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly well-formed traffic near the front, with old, broken and far events.
	task automatic pick_event(output logic [OP_W-1:0] op, output logic [63:0] pn);
		logic [63:0] span;
		int unsigned r;
		r = $urandom_range(0, 99);
		op = event_op();
		pn = front + (($urandom_range(0, 3) == 0) ? 64'd2 : 64'd1);
		if (r < 55) begin
			// in order
		end else if (r < 70) begin
			pn = step_back(64'($urandom_range(0, WINDOW - 1)));
		end else if (r < 78) begin
			pn = front + 64'($urandom_range(4, WINDOW + 6));
		end else if (r < 82) begin
			// right at the edge of the window
			pn = step_back($urandom_range(0, 1) ? 64'(WINDOW) : 64'(WINDOW - 1));
		end else if (r < 86) begin
			if (front > 64'(WINDOW))
				pn = rand_pn() % (front - 64'(WINDOW) + 64'd1);
		end else if (r < 90) begin
			op = OP_BAD;
			pn = rand_pn();
		end else if (r < 94) begin
			pn = front + 64'($urandom_range(WINDOW, 5000));
		end else if (r < 95) begin
			span = PN_MAX - front;
			if (span != 0)
				pn = front + 64'd1 + ({$urandom, $urandom} % span);
		end else if (r < 98) begin
			pn = front;
		end else begin
			pn = rand_pn();
		end
		if (pn > PN_MAX)
			pn = front;
	endtask

	initial begin : receiver
		int unsigned taken;
		int unsigned stall_left;
		int unsigned stall_pct;
		int unsigned cyc;
		bit          held;
		taken = 0;
		stall_left = 0;
		stall_pct = 10;
		cyc = 0;
		held = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (rsp_valid && rsp_ready)
				taken++;
			if (cyc % 2500 == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 5;
					2:       stall_pct = 25;
					default: stall_pct = 60;
				endcase
			end
			if (!held && taken == HOLD_AT) begin
				// long hold-off: the block backs up and stalls requests
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else if (stall_left != 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					stall_left = idle_len() + 1;
			end
		end
	end

	initial begin : stimulus
		logic [OP_W-1:0] op;
		logic [63:0]     pn;
		int              i;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		front = '0;
		loss_pct = 20;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		offer(OP_ACK, 64'd0);
		offer(OP_BAD, PN_MAX);
		offer(OP_BAD, 64'd0);
		offer(OP_LOST, 64'd1);
		offer(OP_REPAIR, 64'd2);
		offer(OP_ACK, 64'd2);
		offer(OP_LOST, 64'(WINDOW + 2));        // gap fill of one short of a window
		offer(OP_REPAIR, 64'd3);                // just inside the window
		offer(OP_LOST, 64'd2);                  // exactly one window behind
		offer(OP_ACK, 64'(2 * WINDOW + 3));     // gap of a full window
		offer(OP_LOST, 64'(2 * WINDOW + 3));
		offer(OP_ACK, 64'(3 * WINDOW + 8));     // clear with nothing lost
		offer(OP_ACK, 64'd0);
		offer(OP_BAD, 64'(3 * WINDOW + 9));

		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 4))
					0:       loss_pct = 0;
					1:       loss_pct = 3;
					2:       loss_pct = 15;
					3:       loss_pct = 50;
					default: loss_pct = 100;
				endcase
				calm = ($urandom_range(0, 4) == 0);
			end
			pick_event(op, pn);
			offer(op, pn);
		end

		offer(OP_LOST, PN_MAX);
		offer(OP_REPAIR, PN_MAX - 64'(WINDOW - 1));
		offer(OP_ACK, PN_MAX - 64'(WINDOW));
		offer(OP_REPAIR, PN_MAX);
		req_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("loss_window_fec_ratio regression: pass");
		else
			$display("loss_window_fec_ratio regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
design/lwfr_pkg.sv
design/lwfr_div.sv
design/loss_window_fec_ratio.sv
bench/lwfr_ratio_checker.sv
bench/loss_window_fec_ratio_tb.sv
